### rtl/core/bounded_slope_stream_compressor_top_macros.svh
// =============================================================================
// Assertion macros for the bounded-slope stream compressor
// Shared property shapes used by the port-level checker.
// =============================================================================
`ifndef BOUNDED_SLOPE_STREAM_COMPRESSOR_TOP_MACROS_SVH
`define BOUNDED_SLOPE_STREAM_COMPRESSOR_TOP_MACROS_SVH

// ante in one cycle implies cons in the next, ignored while in reset
`define BSSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// cons holds in the cycle after a reset cycle
`define BSSC_ASSERT_RST(label, clk, rst_n, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

### rtl/core/bssc_pkg.sv
// =============================================================================
// bssc_pkg
// Shared widths, codes and controller/datapath command types.
// =============================================================================
package bssc_pkg;

  localparam int TIME_W   = 32;
  localparam int SAMP_W   = 16;
  localparam int TOL_W    = 32;
  localparam int AX_BITS  = 3;
  localparam int OUT_AXES = 3;
  localparam int RES_W    = 64;
  localparam int OUT_LIM  = 32768;

  localparam logic [TOL_W-1:0] TOL_RESET = 32'd65536;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FIRST,
    OP_OPEN,
    OP_MUL_A,
    OP_SAVE_A,
    OP_MUL_B,
    OP_TEST,
    OP_EXT,
    OP_EXT_WB,
    OP_CLOSE,
    OP_DIV_HI,
    OP_NARROW_HI,
    OP_DIV_LO,
    OP_NARROW_LO,
    OP_ADVANCE,
    OP_FLUSH_BASE,
    OP_FLUSH_CLR,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t             op;
    logic [AX_BITS-1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic flush;
    logic cnt_zero;
    logic cnt_one;
    logic cnt_two;
    logic unit_done;
    logic outside;
  } dp_stat_t;

endpackage

### rtl/core/bssc_if.sv
// =============================================================================
// bssc_in_if / bssc_out_if
// Valid/ready channels for sample items and emitted segment points.
// =============================================================================
interface bssc_in_if;
  import bssc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [TIME_W-1:0]        sample_time;
  logic signed [SAMP_W-1:0] sample_x;
  logic signed [SAMP_W-1:0] sample_y;
  logic signed [SAMP_W-1:0] sample_z;
  modport source (output valid, action, sample_time, sample_x, sample_y, sample_z,
                  input ready);
  modport sink   (input valid, action, sample_time, sample_x, sample_y, sample_z,
                  output ready);
endinterface

interface bssc_out_if;
  import bssc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [TIME_W-1:0]        point_time;
  logic signed [SAMP_W-1:0] point_x;
  logic signed [SAMP_W-1:0] point_y;
  logic signed [SAMP_W-1:0] point_z;
  logic                     is_final;
  modport source (output valid, point_time, point_x, point_y, point_z, is_final,
                  input ready);
  modport sink   (input valid, point_time, point_x, point_y, point_z, is_final,
                  output ready);
endinterface

### rtl/core/bssc_iter.sv
// =============================================================================
// bssc_iter
// Shared bit-serial unit: saturating multiply (clamp at 2^62) or floor divide
// of a signed operand by an unsigned count.
// =============================================================================
module bssc_iter #(
  parameter int OPW = 36,
  parameter int CB  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           is_div,
  input  logic signed [OPW-1:0]          opnd,
  input  logic [CB-1:0]                  m,
  output logic                           done,
  output logic signed [bssc_pkg::RES_W-1:0] res
);
  import bssc_pkg::*;

  localparam int PW   = OPW + CB;
  localparam int EW   = (PW > RES_W) ? PW : RES_W;
  localparam int CNTW = $clog2(OPW + 1);
  localparam logic [EW-1:0] LIM = EW'(1) << 62;

  logic                     busy_r, fin_r, done_r, div_r, neg_r;
  logic [CNTW-1:0]          cnt_r;
  logic [PW-1:0]            mcand_r, acc_r;
  logic [CB-1:0]            m_r, rem_r;
  logic [OPW-1:0]           num_r, quo_r;
  logic signed [RES_W-1:0]  res_r;

  logic [OPW-1:0]  mag;
  logic [CB:0]     trial;
  logic            qbit;
  logic [EW-1:0]   pext, pmag;
  logic [OPW:0]    qm;

  always_comb begin
    mag   = opnd[OPW-1] ? OPW'(-opnd) : OPW'(opnd);
    trial = {rem_r, num_r[OPW-1]};
    qbit  = (trial >= {1'b0, m_r});
    pext  = EW'(acc_r);
    pmag  = (pext > LIM) ? LIM : pext;
    qm    = (OPW+1)'(quo_r) + (OPW+1)'(neg_r && (rem_r != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        div_r   <= is_div;
        neg_r   <= opnd[OPW-1];
        mcand_r <= PW'(mag);
        acc_r   <= '0;
        num_r   <= mag;
        quo_r   <= '0;
        rem_r   <= '0;
        m_r     <= m;
        cnt_r   <= is_div ? CNTW'(OPW) : CNTW'(CB);
      end else if (busy_r) begin
        if (div_r) begin
          rem_r <= qbit ? CB'(trial - {1'b0, m_r}) : trial[CB-1:0];
          quo_r <= {quo_r[OPW-2:0], qbit};
          num_r <= num_r << 1;
        end else begin
          if (m_r[0]) acc_r <= acc_r + mcand_r;
          mcand_r <= mcand_r << 1;
          m_r     <= m_r >> 1;
        end
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        if (div_r) begin
          res_r <= neg_r ? -RES_W'(qm) : RES_W'(qm);
        end else begin
          res_r <= neg_r ? -RES_W'(pmag) : RES_W'(pmag);
        end
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### rtl/core/bssc_dp.sv
// =============================================================================
// bssc_dp
// Datapath: segment state, box bounds, inside test, narrowing, extrapolation
// and the output register.
// =============================================================================
module bssc_dp #(
  parameter int AXES       = 3,
  parameter int FRAC_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bssc_pkg::dp_cmd_t                     cmd,
  output bssc_pkg::dp_stat_t                    stat,
  input  logic                                  cfg_we,
  input  logic [bssc_pkg::TOL_W-1:0]            cfg_wdata,
  input  logic                                  in_action,
  input  logic [bssc_pkg::TIME_W-1:0]           in_sample_time,
  input  logic signed [bssc_pkg::SAMP_W-1:0]    in_sample_x,
  input  logic signed [bssc_pkg::SAMP_W-1:0]    in_sample_y,
  input  logic signed [bssc_pkg::SAMP_W-1:0]    in_sample_z,
  output logic [bssc_pkg::TIME_W-1:0]           out_point_time,
  output logic signed [bssc_pkg::SAMP_W-1:0]    out_point_x,
  output logic signed [bssc_pkg::SAMP_W-1:0]    out_point_y,
  output logic signed [bssc_pkg::SAMP_W-1:0]    out_point_z,
  output logic                                  out_is_final
);
  import bssc_pkg::*;

  localparam int VB  = FRAC_BITS + 18;
  localparam int NW  = ((VB > TOL_W + 1) ? VB : TOL_W + 1) + 2;
  localparam int WW  = RES_W + 2;
  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int CB  = COUNT_BITS;
  localparam logic signed [WW-1:0] VMAX = (WW'(1) <<< (VB - 1)) - WW'(1);
  localparam logic signed [WW-1:0] VMIN = -VMAX - WW'(1);
  localparam logic signed [WW-1:0] OMAX = WW'(OUT_LIM - 1);
  localparam logic signed [WW-1:0] OMIN = -WW'(OUT_LIM);

  function automatic logic signed [VB-1:0] sat_vb(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] c;
    c = (v > VMAX) ? VMAX : ((v < VMIN) ? VMIN : v);
    return VB'(c);
  endfunction

  // truncate toward zero, then clamp to the 16-bit output range
  function automatic logic signed [SAMP_W-1:0] to_out(input logic signed [VB-1:0] v);
    logic signed [WW-1:0] w, q;
    w = WW'(v);
    q = (w >= 0) ? (w >>> FRAC_BITS) : -((-w) >>> FRAC_BITS);
    q = (q > OMAX) ? OMAX : ((q < OMIN) ? OMIN : q);
    return SAMP_W'(q);
  endfunction

  logic [TOL_W-1:0]           tol_r;
  logic [CB-1:0]              cnt_r;
  logic [TIME_W-1:0]          prev_r, t_r;
  logic                       act_r, outside_r;
  logic signed [SAMP_W-1:0]   raw_r [OUT_AXES];
  logic signed [VB-1:0]       base_r [AXES];
  logic signed [VB-1:0]       ub_r [AXES];
  logic signed [VB-1:0]       lb_r [AXES];
  logic signed [RES_W-1:0]    p1_r;
  logic [TIME_W-1:0]          pend_time_r;
  logic signed [SAMP_W-1:0]   pend_pt_r [OUT_AXES];
  logic                       pend_fin_r;
  logic [TIME_W-1:0]          o_time_r;
  logic signed [SAMP_W-1:0]   o_pt_r [OUT_AXES];
  logic                       o_fin_r;

  logic signed [WW-1:0]  s_all [AXES];
  logic signed [VB-1:0]  box_hi [AXES];
  logic signed [VB-1:0]  box_lo [AXES];
  logic signed [WW-1:0]  ev;

  genvar g;
  generate
    for (g = 0; g < AXES; g++) begin : g_ax
      if (g < OUT_AXES) begin : g_in
        assign s_all[g] = WW'(raw_r[g]) <<< FRAC_BITS;
      end else begin : g_zero
        assign s_all[g] = '0;
      end
      assign box_hi[g] = sat_vb(s_all[g] + ev);
      assign box_lo[g] = sat_vb(s_all[g] - ev);
    end
  endgenerate

  logic [AXW-1:0]          ax;
  logic                    ax_out;
  logic [1:0]              oax;
  logic signed [WW-1:0]    bv, uv, lv, sv, rw, lhs, rhs, alhs;
  logic signed [VB-1:0]    ext_b, hi_new, lo_new;
  logic [CB-1:0]           d, k;
  logic                    u_start, u_div, u_done;
  logic signed [NW-1:0]    u_opnd;
  logic signed [RES_W-1:0] u_res;

  always_comb begin
    ax     = cmd.axis[AXW-1:0];
    ax_out = (cmd.axis < AX_BITS'(OUT_AXES));
    oax    = cmd.axis[1:0];
    ev     = WW'(tol_r);
    bv     = WW'(base_r[ax]);
    uv     = WW'(ub_r[ax]);
    lv     = WW'(lb_r[ax]);
    sv     = s_all[ax];
    rw     = WW'(u_res);
    d      = cnt_r - CB'(1);
    k      = (act_r == ACT_FLUSH) ? (cnt_r - CB'(1)) : (cnt_r - CB'(2));
    lhs    = WW'(p1_r) + ((sv - bv) <<< 1);
    rhs    = rw + (ev <<< 1);
    alhs   = (lhs < 0) ? -lhs : lhs;
    ext_b  = sat_vb(bv + (rw >>> 1));
    hi_new = sat_vb(bv + rw);
    lo_new = sat_vb(bv - rw);
    u_start = 1'b0;
    u_div   = 1'b0;
    u_opnd  = '0;
    unique case (cmd.op)
      OP_MUL_A: begin u_start = 1'b1; u_opnd = NW'((bv <<< 1) - uv - lv); end
      OP_MUL_B: begin u_start = 1'b1; u_opnd = NW'(uv - lv); end
      OP_EXT:   begin u_start = 1'b1; u_opnd = NW'(uv + lv - (bv <<< 1)); end
      OP_DIV_HI: begin
        u_start = 1'b1; u_div = 1'b1; u_opnd = NW'(sv - bv + ev);
      end
      OP_DIV_LO: begin
        u_start = 1'b1; u_div = 1'b1; u_opnd = NW'(bv + ev - sv);
      end
      default: ;
    endcase
  end

  bssc_iter #(.OPW(NW), .CB(CB)) u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (u_start),
    .is_div (u_div),
    .opnd   (u_opnd),
    .m      ((cmd.op == OP_EXT) ? k : d),
    .done   (u_done),
    .res    (u_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r     <= TOL_RESET;
      cnt_r     <= '0;
      prev_r    <= '0;
      outside_r <= 1'b0;
    end else begin
      if (cfg_we) tol_r <= cfg_wdata;
      unique case (cmd.op)
        OP_LOAD: begin
          act_r     <= in_action;
          t_r       <= in_sample_time;
          raw_r[0]  <= in_sample_x;
          raw_r[1]  <= in_sample_y;
          raw_r[2]  <= in_sample_z;
          outside_r <= 1'b0;
          for (int i = 0; i < OUT_AXES; i++) pend_pt_r[i] <= '0;
          if (in_action == ACT_SAMPLE && cnt_r != '1) cnt_r <= cnt_r + CB'(1);
        end
        OP_FIRST: begin
          for (int i = 0; i < AXES; i++) base_r[i] <= VB'(s_all[i]);
          for (int i = 0; i < OUT_AXES; i++) pend_pt_r[i] <= raw_r[i];
          prev_r      <= t_r;
          pend_time_r <= t_r;
          pend_fin_r  <= 1'b0;
        end
        OP_OPEN: begin
          for (int i = 0; i < AXES; i++) begin
            ub_r[i] <= box_hi[i];
            lb_r[i] <= box_lo[i];
          end
          prev_r <= t_r;
        end
        OP_SAVE_A: p1_r <= u_res;
        OP_TEST:   if (alhs >= rhs) outside_r <= 1'b1;
        OP_EXT_WB: begin
          if (act_r == ACT_SAMPLE) base_r[ax] <= ext_b;
          if (ax_out) pend_pt_r[oax] <= to_out(ext_b);
        end
        OP_CLOSE: begin
          for (int i = 0; i < AXES; i++) begin
            ub_r[i] <= box_hi[i];
            lb_r[i] <= box_lo[i];
          end
          pend_time_r <= prev_r;
          pend_fin_r  <= 1'b0;
          prev_r      <= t_r;
          cnt_r       <= CB'(2);
        end
        OP_NARROW_HI: if (hi_new < ub_r[ax]) ub_r[ax] <= hi_new;
        OP_NARROW_LO: if (lo_new > lb_r[ax]) lb_r[ax] <= lo_new;
        OP_ADVANCE:   prev_r <= t_r;
        OP_FLUSH_BASE: begin
          for (int i = 0; i < OUT_AXES; i++) begin
            pend_pt_r[i] <= (i < AXES) ? to_out(base_r[i % AXES]) : '0;
          end
        end
        OP_FLUSH_CLR: begin
          pend_time_r <= prev_r;
          pend_fin_r  <= 1'b1;
          cnt_r       <= '0;
          prev_r      <= '0;
        end
        OP_EMIT: begin
          o_time_r <= pend_time_r;
          o_fin_r  <= pend_fin_r;
          for (int i = 0; i < OUT_AXES; i++) o_pt_r[i] <= pend_pt_r[i];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.flush     = (act_r == ACT_FLUSH);
    stat.cnt_zero  = (cnt_r == CB'(0));
    stat.cnt_one   = (cnt_r == CB'(1));
    stat.cnt_two   = (cnt_r == CB'(2));
    stat.unit_done = u_done;
    stat.outside   = outside_r;
  end

  assign out_point_time = o_time_r;
  assign out_point_x    = o_pt_r[0];
  assign out_point_y    = o_pt_r[1];
  assign out_point_z    = o_pt_r[2];
  assign out_is_final   = o_fin_r;

endmodule

### rtl/core/bssc_ctrl.sv
// =============================================================================
// bssc_ctrl
// Sequencer: walks the axes through test, then narrow or extrapolate and close,
// handles flushes, and owns the channel handshakes.
// =============================================================================
module bssc_ctrl #(
  parameter int AXES = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bssc_pkg::dp_cmd_t   cmd,
  input  bssc_pkg::dp_stat_t  stat
);
  import bssc_pkg::*;

  localparam logic [AX_BITS-1:0] AX_LAST = AX_BITS'(AXES - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_MA, S_MA_W, S_MB, S_MB_W, S_DECIDE, S_EXT, S_EXT_W,
    S_CLOSE, S_DH, S_DH_W, S_DL, S_DL_W, S_ADV, S_FCLR, S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [AX_BITS-1:0] ax_r, ax_nxt;
  logic               out_valid_r, out_valid_nxt;
  dp_op_t             op;

  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    op            = OP_NONE;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        op = OP_LOAD;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        ax_nxt = '0;
        priority if (stat.flush && stat.cnt_zero) begin
          op = OP_FLUSH_CLR; state_nxt = S_IDLE;
        end else if (stat.flush && stat.cnt_one) begin
          op = OP_FLUSH_BASE; state_nxt = S_FCLR;
        end else if (stat.flush) begin
          state_nxt = S_EXT;
        end else if (stat.cnt_one) begin
          op = OP_FIRST; state_nxt = S_EMIT;
        end else if (stat.cnt_two) begin
          op = OP_OPEN; state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MA;
        end
      end
      S_MA: begin op = OP_MUL_A; state_nxt = S_MA_W; end
      S_MA_W: if (stat.unit_done) begin op = OP_SAVE_A; state_nxt = S_MB; end
      S_MB: begin op = OP_MUL_B; state_nxt = S_MB_W; end
      S_MB_W: if (stat.unit_done) begin
        op = OP_TEST;
        if (ax_r == AX_LAST) state_nxt = S_DECIDE;
        else begin ax_nxt = ax_r + AX_BITS'(1); state_nxt = S_MA; end
      end
      S_DECIDE: begin
        ax_nxt    = '0;
        state_nxt = stat.outside ? S_EXT : S_DH;
      end
      S_EXT: begin op = OP_EXT; state_nxt = S_EXT_W; end
      S_EXT_W: if (stat.unit_done) begin
        op = OP_EXT_WB;
        if (ax_r == AX_LAST) state_nxt = stat.flush ? S_FCLR : S_CLOSE;
        else begin ax_nxt = ax_r + AX_BITS'(1); state_nxt = S_EXT; end
      end
      S_CLOSE: begin op = OP_CLOSE; state_nxt = S_EMIT; end
      S_DH: begin op = OP_DIV_HI; state_nxt = S_DH_W; end
      S_DH_W: if (stat.unit_done) begin op = OP_NARROW_HI; state_nxt = S_DL; end
      S_DL: begin op = OP_DIV_LO; state_nxt = S_DL_W; end
      S_DL_W: if (stat.unit_done) begin
        op = OP_NARROW_LO;
        if (ax_r == AX_LAST) state_nxt = S_ADV;
        else begin ax_nxt = ax_r + AX_BITS'(1); state_nxt = S_DH; end
      end
      S_ADV: begin op = OP_ADVANCE; state_nxt = S_IDLE; end
      S_FCLR: begin op = OP_FLUSH_CLR; state_nxt = S_EMIT; end
      S_EMIT: if (!out_valid_r || out_ready) begin
        op = OP_EMIT;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign cmd.op    = op;
  assign cmd.axis  = ax_r;

endmodule

### rtl/core/bounded_slope_stream_compressor_top.sv
// Sequence: a first sample is stored for output; a flush with samples held extrapolates
//   each axis, or takes the base, then clears and emits; a closing sample tests and
//   extrapolates each axis, then closes and emits; a narrowing sample tests, then
//   divides, on each axis. Items: one at a time, the bit-serial unit setting the rate.
// Reset: synchronous; count and previous time cleared, tolerance 1.0 LSB, no clearing pass.
// =============================================================================
// bounded_slope_stream_compressor_top
// Swing-filter compression of timestamped three-axis samples into segments.
// =============================================================================
module bounded_slope_stream_compressor_top #(
  parameter int AXES       = 3,
  parameter int FRAC_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bssc_in_if.sink                      in_ch,
  bssc_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [bssc_pkg::TOL_W-1:0]   cfg_wdata
);
  import bssc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bssc_ctrl #(.AXES(AXES)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  bssc_dp #(.AXES(AXES), .FRAC_BITS(FRAC_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_action      (in_ch.action),
    .in_sample_time (in_ch.sample_time),
    .in_sample_x    (in_ch.sample_x),
    .in_sample_y    (in_ch.sample_y),
    .in_sample_z    (in_ch.sample_z),
    .out_point_time (out_ch.point_time),
    .out_point_x    (out_ch.point_x),
    .out_point_y    (out_ch.point_y),
    .out_point_z    (out_ch.point_z),
    .out_is_final   (out_ch.is_final)
  );

endmodule

### rtl/core/bssc_chk.sv
// =============================================================================
// bssc_chk
// Port-level checks on the compressor, bound to the top level.
// =============================================================================
`include "bounded_slope_stream_compressor_top_macros.svh"

module bssc_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [bssc_pkg::TIME_W-1:0]        out_point_time,
  input logic signed [bssc_pkg::SAMP_W-1:0] out_point_x,
  input logic signed [bssc_pkg::SAMP_W-1:0] out_point_y,
  input logic signed [bssc_pkg::SAMP_W-1:0] out_point_z,
  input logic                               out_is_final
);

  `BSSC_ASSERT_RST(a_rst_idle, clk, rst_n, !out_valid && in_ready, "not idle after reset")

  // an accepted beat leaves the block busy in the following cycle
  `BSSC_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready, "ready after accept")

  `BSSC_ASSERT_NEXT(a_no_fast_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid), "result too early")

  `BSSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_point_time) && $stable(out_point_x) && $stable(out_point_y) && $stable(out_point_z) && $stable(out_is_final), "stalled beat changed")

endmodule

bind bounded_slope_stream_compressor_top bssc_chk u_bssc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_point_time (out_ch.point_time),
  .out_point_x    (out_ch.point_x),
  .out_point_y    (out_ch.point_y),
  .out_point_z    (out_ch.point_z),
  .out_is_final   (out_ch.is_final)
);
